FILE: sv/gtpm_pkg.sv
// gtpm_pkg: shared widths, reset values, register indexes and item types
// for the gyro-to-pointer motion unit; no dependencies
package gtpm_pkg;

  localparam int RATE_W     = 20;
  localparam int STATE_W    = 21;
  localparam int OUT_W      = 8;
  localparam int ALPHA_W    = 17;
  localparam int THR_W      = 19;
  localparam int GAIN_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;
  localparam int Q_FRAC     = 16;
  localparam int Q_ROUND    = (1 << Q_FRAC) - 1;

  // sample minus state, times alpha as signed
  localparam int DIFF_W = STATE_W + 1;
  localparam int MUL1_W = DIFF_W + ALPHA_W + 1;
  localparam int SUM_W  = MUL1_W - Q_FRAC;
  // filtered state times gain as signed
  localparam int MUL2_W = STATE_W + GAIN_W + 1;
  localparam int TRUNC_W = MUL2_W - Q_FRAC;

  localparam int SAT_MAX = 127;
  localparam int SAT_MIN = -128;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(1 << Q_FRAC);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(52429);
  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(1280);
  localparam logic [GAIN_W-1:0]  PGAIN_RESET = GAIN_W'(19661);
  localparam logic [GAIN_W-1:0]  WGAIN_RESET = GAIN_W'(3277);
  localparam logic signed [STATE_W-1:0] STATE_RESET = STATE_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA        = 2'd0,
    CFG_THRESHOLD    = 2'd1,
    CFG_POINTER_GAIN = 2'd2,
    CFG_WHEEL_GAIN   = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] move_horizontal;
    logic signed [OUT_W-1:0] move_vertical;
    logic signed [OUT_W-1:0] wheel_step;
  } out_item_t;

  typedef struct packed {
    logic load_mul;
    logic load_filt;
    logic load_gain;
  } lane_ctrl_t;

endpackage

FILE: sv/gtpm_lane.sv
// gtpm_lane: one axis of the motion unit, low-pass filter with deadband
// and gain multiply, three register stages; depends on gtpm_pkg
module gtpm_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  gtpm_pkg::lane_ctrl_t                 ctrl,
  input  logic signed [gtpm_pkg::RATE_W-1:0]   sample,
  input  logic [gtpm_pkg::ALPHA_W-1:0]         alpha,
  input  logic [gtpm_pkg::THR_W-1:0]           threshold,
  input  logic [gtpm_pkg::GAIN_W-1:0]          gain,
  output logic signed [gtpm_pkg::MUL2_W-1:0]   product
);

  logic signed [gtpm_pkg::STATE_W-1:0] state;
  logic signed [gtpm_pkg::MUL1_W-1:0]  mul1;
  logic signed [gtpm_pkg::STATE_W-1:0] filt;

  logic [gtpm_pkg::ALPHA_W-1:0]         alpha_eff;
  logic signed [gtpm_pkg::DIFF_W-1:0]   diff;
  logic signed [gtpm_pkg::MUL1_W-1:0]   mul1_next;
  logic signed [gtpm_pkg::SUM_W-1:0]    sum;
  logic signed [gtpm_pkg::STATE_W-1:0]  f_trim;
  logic [gtpm_pkg::STATE_W-1:0]         mag;
  logic signed [gtpm_pkg::STATE_W-1:0]  f_gated;
  logic signed [gtpm_pkg::MUL2_W-1:0]   mul2_next;

  always_comb begin
    alpha_eff = (alpha > gtpm_pkg::ALPHA_ONE) ? gtpm_pkg::ALPHA_ONE : alpha;
    // alpha*s + (1-alpha)*st == st + alpha*(s - st), low bits of st<<16 are zero
    diff = gtpm_pkg::DIFF_W'(sample) - gtpm_pkg::DIFF_W'(state);
    mul1_next = diff * signed'({1'b0, alpha_eff});
    sum = gtpm_pkg::SUM_W'(state) + signed'(mul1[gtpm_pkg::MUL1_W-1:gtpm_pkg::Q_FRAC]);
    f_trim = sum[gtpm_pkg::STATE_W-1:0];
    mag = f_trim[gtpm_pkg::STATE_W-1] ? gtpm_pkg::STATE_W'(-f_trim)
                                      : gtpm_pkg::STATE_W'(f_trim);
    f_gated = (mag < gtpm_pkg::STATE_W'(threshold)) ? '0 : f_trim;
    mul2_next = filt * signed'({1'b0, gain});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gtpm_pkg::STATE_RESET;
    end else if (ctrl.load_filt) begin
      state <= f_gated;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_mul) begin
      mul1 <= mul1_next;
    end
    if (ctrl.load_filt) begin
      filt <= f_gated;
    end
    if (ctrl.load_gain) begin
      product <= mul2_next;
    end
  end

endmodule

FILE: sv/gtpm_merge.sv
// gtpm_merge: truncates and saturates the three lane products, negates x and z,
// drops all-zero motion and holds the output register; depends on gtpm_pkg
module gtpm_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                prod_valid,
  input  logic signed [gtpm_pkg::MUL2_W-1:0]  prod_x,
  input  logic signed [gtpm_pkg::MUL2_W-1:0]  prod_y,
  input  logic signed [gtpm_pkg::MUL2_W-1:0]  prod_z,
  output logic                                take,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gtpm_pkg::out_item_t                 out_item
);

  function automatic logic signed [gtpm_pkg::OUT_W-1:0] scale_out(
    input logic signed [gtpm_pkg::MUL2_W-1:0] p,
    input logic                               neg
  );
    logic signed [gtpm_pkg::MUL2_W-1:0]  bias;
    logic signed [gtpm_pkg::MUL2_W-1:0]  biased;
    logic signed [gtpm_pkg::TRUNC_W-1:0] t;
    logic signed [gtpm_pkg::TRUNC_W-1:0] v;
    logic signed [gtpm_pkg::OUT_W-1:0]   r;
    // toward zero: bias negatives before the arithmetic shift
    bias = p[gtpm_pkg::MUL2_W-1] ? gtpm_pkg::MUL2_W'(gtpm_pkg::Q_ROUND) : '0;
    biased = p + bias;
    t = signed'(biased[gtpm_pkg::MUL2_W-1:gtpm_pkg::Q_FRAC]);
    v = neg ? -t : t;
    if (v > gtpm_pkg::TRUNC_W'(gtpm_pkg::SAT_MAX)) begin
      r = gtpm_pkg::OUT_W'(gtpm_pkg::SAT_MAX);
    end else if (v < gtpm_pkg::TRUNC_W'(gtpm_pkg::SAT_MIN)) begin
      r = gtpm_pkg::OUT_W'(gtpm_pkg::SAT_MIN);
    end else begin
      r = v[gtpm_pkg::OUT_W-1:0];
    end
    return r;
  endfunction

  gtpm_pkg::out_item_t res;
  logic                any_motion;

  always_comb begin
    res.move_horizontal = scale_out(prod_z, 1'b1);
    res.move_vertical   = scale_out(prod_x, 1'b1);
    res.wheel_step      = scale_out(prod_y, 1'b0);
    any_motion = (res.move_horizontal != '0) || (res.move_vertical != '0) ||
                 (res.wheel_step != '0);
    take = prod_valid && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= any_motion;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item <= res;
    end
  end

endmodule

FILE: sv/gyro_to_pointer_motion_unit.sv
// Gyro-to-pointer motion unit: one three-axis gyro rate sample in, at most
// one pointer/wheel motion item out. Each axis runs in its own lane; a new
// item is accepted only after the last one leaves the filter stage, set by
// the filter feedback loop (alpha multiply into mul1, then state add,
// deadband and state write). A result passes the mul1, filt and product
// registers to the output register; samples whose three outputs are all
// zero still update the filters but produce no output item. Configuration
// writes are always ready. Depends on gtpm_pkg, gtpm_lane and gtpm_merge.
module gyro_to_pointer_motion_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  gtpm_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output gtpm_pkg::out_item_t                  out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gtpm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gtpm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [gtpm_pkg::ALPHA_W-1:0] alpha;
  logic [gtpm_pkg::THR_W-1:0]   threshold;
  logic [gtpm_pkg::GAIN_W-1:0]  pointer_gain;
  logic [gtpm_pkg::GAIN_W-1:0]  wheel_gain;

  logic v1;
  logic v2;
  logic v3;

  logic accept;
  logic adv1;
  logic adv2;
  logic take;
  gtpm_pkg::lane_ctrl_t ctrl;

  logic signed [gtpm_pkg::MUL2_W-1:0] prod_x;
  logic signed [gtpm_pkg::MUL2_W-1:0] prod_y;
  logic signed [gtpm_pkg::MUL2_W-1:0] prod_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha        <= gtpm_pkg::ALPHA_RESET;
      threshold    <= gtpm_pkg::THR_RESET;
      pointer_gain <= gtpm_pkg::PGAIN_RESET;
      wheel_gain   <= gtpm_pkg::WGAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (gtpm_pkg::cfg_index_t'(cfg_index))
        gtpm_pkg::CFG_ALPHA: begin
          alpha <= cfg_data[gtpm_pkg::ALPHA_W-1:0];
        end
        gtpm_pkg::CFG_THRESHOLD: begin
          threshold <= cfg_data[gtpm_pkg::THR_W-1:0];
        end
        gtpm_pkg::CFG_POINTER_GAIN: begin
          pointer_gain <= cfg_data[gtpm_pkg::GAIN_W-1:0];
        end
        gtpm_pkg::CFG_WHEEL_GAIN: begin
          wheel_gain <= cfg_data[gtpm_pkg::GAIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // a new sample needs the filter state written back, so stage 1 must be empty
  always_comb begin
    in_ready = !v1;
    accept = in_valid && in_ready;
    adv2 = v2 && !(v3 && !take);
    adv1 = v1 && !(v2 && !adv2);
    ctrl.load_mul  = accept;
    ctrl.load_filt = adv1;
    ctrl.load_gain = adv2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (accept) begin
        v1 <= 1'b1;
      end else if (adv1) begin
        v1 <= 1'b0;
      end
      if (adv1) begin
        v2 <= 1'b1;
      end else if (adv2) begin
        v2 <= 1'b0;
      end
      if (adv2) begin
        v3 <= 1'b1;
      end else if (take) begin
        v3 <= 1'b0;
      end
    end
  end

  gtpm_lane u_lane_x (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .sample    (in_item.rate_x),
    .alpha     (alpha),
    .threshold (threshold),
    .gain      (pointer_gain),
    .product   (prod_x)
  );

  gtpm_lane u_lane_y (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .sample    (in_item.rate_y),
    .alpha     (alpha),
    .threshold (threshold),
    .gain      (wheel_gain),
    .product   (prod_y)
  );

  gtpm_lane u_lane_z (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .sample    (in_item.rate_z),
    .alpha     (alpha),
    .threshold (threshold),
    .gain      (pointer_gain),
    .product   (prod_z)
  );

  gtpm_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (v3),
    .prod_x     (prod_x),
    .prod_y     (prod_y),
    .prod_z     (prod_z),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input taken while previous item still in the filter stage");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (v3 && out_valid && !out_ready) |=> v3)
    else $error("last stage item lost while output stalled");

  a_no_skip_stage: assert property (@(posedge clk) disable iff (rst)
    (v2 && v3 && !take) |=> v2)
    else $error("filter stage item dropped behind a stalled stage");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule
